[hdl/hsvsb_pkg.sv]
`default_nettype none
package hsvsb_pkg;
	localparam int ChBits = 8;
	localparam int OfsBits = ChBits + 1;
	localparam int HueBits = 11;
	localparam int QBits = 9;
	localparam logic [ChBits-1:0] Full = {ChBits{1'b1}};
	localparam logic [0:0] RegSat = 1'b0;
	localparam logic [0:0] RegBright = 1'b1;
	localparam logic [HueBits-1:0] HueRange = 11'd1536;

	typedef logic [ChBits-1:0] ch_t;
	typedef logic signed [OfsBits-1:0] ofs_t;
	typedef logic [HueBits-1:0] hue_t;

	typedef struct packed {
		logic [1:0] max_sel;
		logic       neg;
		ch_t        num;
		ch_t        diff;
		ch_t        mx;
	} hsvsb_pre_t;

	typedef struct packed {
		hue_t hue;
		ch_t  s;
		ch_t  v;
	} hsvsb_hsv_t;

	localparam logic [1:0] SelRed = 2'd0;
	localparam logic [1:0] SelGreen = 2'd1;
	localparam logic [1:0] SelBlue = 2'd2;
endpackage
`default_nettype wire

[hdl/hsvsb_divstage.sv]
`default_nettype none
module hsvsb_divstage (
	input  wire logic [16:0] rem_in,
	input  wire logic [7:0]  den,
	input  wire logic [7:0]  qin,
	output logic [16:0]      rem_out,
	output logic [7:0]       qout,
	input  wire logic [2:0]  bitpos
);
	import hsvsb_pkg::*;
	logic [16:0] trial;
	always_comb begin
		trial = {9'd0, den} << bitpos;
		if (rem_in >= trial) begin
			rem_out = rem_in - trial;
			qout = qin | (8'd1 << bitpos);
		end else begin
			rem_out = rem_in;
			qout = qin;
		end
	end
endmodule
`default_nettype wire

[hdl/hsv_saturation_brightness_adjust.sv]
// RGB pixel saturation/brightness adjuster.
// Slave channel s_axis_*: one pixel per word, tdata = {blue, green, red}.
// Master channel m_axis_*: adjusted pixel, tdata = {blue, green, red},
// tuser = clamped (adjusted S or V hit 0 or full scale).
// Config channel cfg_*: index 0 = sat_offset, 1 = bright_offset, 9-bit
// signed; other indexes are ignored. Write only while the pipe is empty.
// Throughput: one pixel per clock; the pipe advances whenever the last
// stage is empty or taken. The two dividers (hue fraction and
// saturation) are spread over the stages, two restoring steps per stage.
// Reset clears all valid bits and both offsets to 0.
// When the receiver stalls a valid result, s_axis_tready drops and
// every stage holds; no word is lost or repeated.
`default_nettype none
module hsv_saturation_brightness_adjust (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // red_out, green_out, blue_out
	output logic             m_axis_tuser,   // clamped
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);
	import hsvsb_pkg::*;
	localparam int NS = 8;

	ofs_t sat_q, bri_q;
	logic [NS:1] vld;
	logic adv;
	assign adv = !vld[NS] || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= '0;
			bri_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == RegSat) sat_q <= cfg_data;
			else bri_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld <= '0;
		else if (adv) vld <= {vld[NS-1:1], s_axis_tvalid};
	end

	// stage 1: max, min, diff, hue numerator
	ch_t r, g, b, mx, mn;
	hsvsb_pre_t pre;
	assign r = s_axis_tdata[7:0];
	assign g = s_axis_tdata[15:8];
	assign b = s_axis_tdata[23:16];
	always_comb begin
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		pre.mx = mx;
		pre.diff = mx - mn;
		if (r == mx) begin
			pre.max_sel = SelRed;
			pre.neg = g < b;
			pre.num = (g >= b) ? g - b : b - g;
		end else if (g == mx) begin
			pre.max_sel = SelGreen;
			pre.neg = b < r;
			pre.num = (b >= r) ? b - r : r - b;
		end else begin
			pre.max_sel = SelBlue;
			pre.neg = r < g;
			pre.num = (r >= g) ? r - g : g - r;
		end
	end
	hsvsb_pre_t pre_s1;
	always_ff @(posedge clk) if (adv) pre_s1 <= pre;

	// stages 2..5: two dividers, quotient bits 8..0; 256*num/diff < 512
	// hue: rem = num<<8, q 9 bits (only if num==diff q=256)
	// sat: rem = 255*diff + mx/2, q 8 bits
	logic [16:0] hrem [2:5];
	logic [8:0]  hq   [2:5];
	logic [16:0] srem [2:5];
	logic [7:0]  sq   [2:5];
	hsvsb_pre_t  pr   [2:5];

	logic [16:0] hr_n [2:5];
	logic [8:0]  hq_n [2:5];
	logic [16:0] sr_n [2:5];
	logic [7:0]  sq_n [2:5];

	logic [16:0] h_top, h_num, h_init;
	logic        h_msb;
	always_comb begin
		h_top = {1'b0, pre_s1.diff, 8'd0};
		h_num = {1'b0, pre_s1.num, 8'd0};
		h_msb = pre_s1.diff != 0 && h_num >= h_top;
		h_init = h_msb ? h_num - h_top : h_num;
	end

	// each stage does two quotient bits of each divider (8 bits total; bit 8
	// of hue handled in stage 2 by a compare)
	for (genvar gs = 2; gs <= 5; gs++) begin : g_div
		logic [16:0] h_a, h_b, s_a, s_b;
		logic [7:0]  hq_a, hq_b, hq_c, sq_a, sq_b;
		logic        h8_a;
		hsvsb_pre_t  p_a;
		if (gs == 2) begin : g_first
			assign h_a = h_init;
			assign hq_a = '0;
			assign h8_a = h_msb;
			assign s_a = 17'(({9'd0, pre_s1.diff} << 8) - {9'd0, pre_s1.diff})
				+ 17'(pre_s1.mx >> 1);
			assign sq_a = '0;
			assign p_a = pre_s1;
		end else begin : g_next
			assign h_a = hrem[gs-1];
			assign hq_a = hq[gs-1][7:0];
			assign h8_a = hq[gs-1][8];
			assign s_a = srem[gs-1];
			assign sq_a = sq[gs-1];
			assign p_a = pr[gs-1];
		end
		hsvsb_divstage u_hue_hi (.rem_in(h_a), .den(p_a.diff), .qin(hq_a),
			.rem_out(h_b), .qout(hq_b), .bitpos(3'(11 - 2 * gs)));
		hsvsb_divstage u_hue_lo (.rem_in(h_b), .den(p_a.diff), .qin(hq_b),
			.rem_out(hr_n[gs]), .qout(hq_c), .bitpos(3'(10 - 2 * gs)));
		assign hq_n[gs] = {h8_a, hq_c};
		hsvsb_divstage u_sat_hi (.rem_in(s_a), .den(p_a.mx), .qin(sq_a),
			.rem_out(s_b), .qout(sq_b), .bitpos(3'(11 - 2 * gs)));
		hsvsb_divstage u_sat_lo (.rem_in(s_b), .den(p_a.mx), .qin(sq_b),
			.rem_out(sr_n[gs]), .qout(sq_n[gs]), .bitpos(3'(10 - 2 * gs)));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int st = 2; st <= 5; st++) begin
				hrem[st] <= hr_n[st]; hq[st] <= hq_n[st];
				srem[st] <= sr_n[st]; sq[st] <= sq_n[st];
			end
			pr[2] <= pre_s1;
			for (int st = 3; st <= 5; st++) pr[st] <= pr[st-1];
		end
	end

	// stage 6: hue, S', V', clamp flag
	hsvsb_hsv_t hsv;
	logic clamp;
	always_comb begin
		logic [11:0] base, h;
		logic signed [10:0] s2, v2;
		logic [QBits-1:0] q;
		q = (pr[5].diff == 0) ? 9'd0 : hq[5];
		case (pr[5].max_sel)
			SelRed:   base = 12'd0;
			SelGreen: base = 12'd512;
			default:  base = 12'd1024;
		endcase
		h = pr[5].neg ? base + {1'b0, HueRange} - {3'd0, q} : base + {3'd0, q};
		if (h >= {1'b0, HueRange}) h = h - {1'b0, HueRange};
		hsv.hue = h[10:0];
		s2 = $signed({3'd0, (pr[5].mx == 0) ? 8'd0 : sq[5]}) + 11'(sat_q);
		v2 = $signed({3'd0, pr[5].mx}) + 11'(bri_q);
		clamp = 1'b0;
		if (s2 < 0) begin hsv.s = 8'd0; clamp = 1'b1; end
		else if (s2 > 11'sd255) begin hsv.s = Full; clamp = 1'b1; end
		else hsv.s = s2[7:0];
		if (v2 < 0) begin hsv.v = 8'd0; clamp = 1'b1; end
		else if (v2 > 11'sd255) begin hsv.v = Full; clamp = 1'b1; end
		else hsv.v = v2[7:0];
	end
	hsvsb_hsv_t hsv_s6;
	logic clamp_s6;
	logic [15:0] prod_s6;
	always_ff @(posedge clk) begin
		if (adv) begin hsv_s6 <= hsv; clamp_s6 <= clamp; end
	end
	assign prod_s6 = hsv_s6.s * hsv_s6.v;

	// stage 7: C = round(S*V/255)
	ch_t c_s7;
	hsvsb_hsv_t hsv_s7;
	logic clamp_s7;
	logic [16:0] pr7;
	logic [8:0] c9;
	always_comb begin
		pr7 = {1'b0, prod_s6} + 17'd127;
		// floor(p/255) = (p + (p>>8) + 1) >> 8 for p < 65536+
		c9 = 9'((pr7 + (pr7 >> 8) + 17'd1) >> 8);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s7 <= c9[7:0]; hsv_s7 <= hsv_s6; clamp_s7 <= clamp_s6;
		end
	end

	// stage 8: X, m, sector mapping
	logic [23:0] pix;
	always_comb begin
		logic [2:0] sec;
		logic [8:0] t;
		logic [16:0] xp;
		ch_t x, m, ro, go, bo;
		sec = 3'(hsv_s7.hue >> 8);
		t = sec[0] ? 9'd256 - {1'b0, hsv_s7.hue[7:0]} : {1'b0, hsv_s7.hue[7:0]};
		xp = c_s7 * t + 17'd128;
		x = xp[15:8];
		m = hsv_s7.v - c_s7;
		case (sec)
			3'd0: begin ro = c_s7; go = x; bo = '0; end
			3'd1: begin ro = x; go = c_s7; bo = '0; end
			3'd2: begin ro = '0; go = c_s7; bo = x; end
			3'd3: begin ro = '0; go = x; bo = c_s7; end
			3'd4: begin ro = x; go = '0; bo = c_s7; end
			default: begin ro = c_s7; go = '0; bo = x; end
		endcase
		pix = {bo + m, go + m, ro + m};
	end
	always_ff @(posedge clk) begin
		if (adv) begin m_axis_tdata <= pix; m_axis_tuser <= clamp_s7; end
	end
	assign m_axis_tvalid = vld[NS];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld[NS] |-> s_axis_tready) else $error("ready low with empty tail");
endmodule
`default_nettype wire
